// ----- hw/rtl/foc_phase_voltage_modulator_defines.svh -----
// Assertion macros of the phase voltage modulator RTL.
// No dependencies; included by foc_phase_voltage_modulator, which carries the assertions.
`ifndef FOC_PHASE_VOLTAGE_MODULATOR_DEFINES_SVH
`define FOC_PHASE_VOLTAGE_MODULATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FPVM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define FPVM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/fpvm_pkg.sv -----
// Shared constants, types and tables of the phase voltage modulator.
// No dependencies; used by fpvm_sine_rom and foc_phase_voltage_modulator.
package fpvm_pkg;

	// field widths
	localparam int ANGLE_BITS = 16;
	localparam int VOLT_BITS  = 16;
	localparam int LIM_BITS   = VOLT_BITS - 1;
	localparam int OUT_BITS   = VOLT_BITS + 2;
	localparam int PROD_BITS  = 2 * VOLT_BITS;

	// sine table geometry: one turn, stored as one quadrant
	localparam int ROM_DEPTH = 1024;
	localparam int ROM_AW    = $clog2(ROM_DEPTH);
	localparam int QTR       = ROM_DEPTH / 4;
	localparam int QTR_AW    = ROM_AW - 2;
	localparam longint unsigned Q_STEP = 64'd65536 / QTR;

	localparam logic signed [VOLT_BITS-1:0] SQRT3_2_Q15 = 16'sd28378;
	localparam logic [14:0] SIN_PEAK = 15'd32767;
	localparam logic [ANGLE_BITS-1:0] TRAP_OFS = ANGLE_BITS'((64'd1 << ANGLE_BITS) / 12);

	typedef enum logic [1:0] {
		MODE_SINE    = 2'd0,
		MODE_SVPWM   = 2'd1,
		MODE_TRAP120 = 2'd2,
		MODE_TRAP150 = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_MODE     = 2'd0,
		REG_CENTERED = 2'd1,
		REG_LIMIT    = 2'd2
	} reg_idx_t;

	// trapezoid phase coefficient codes
	typedef logic [1:0] coef_t;
	localparam coef_t COEF_ZERO = 2'b00;
	localparam coef_t COEF_POS  = 2'b01;
	localparam coef_t COEF_NEG  = 2'b11;

	typedef logic [QTR-1:0][14:0] qtr_tab_t;

	// polynomial sine of one quadrant entry, Q0.15 magnitude
	function automatic logic [14:0] sin_entry(input longint unsigned f);
		longint unsigned x, x2, t, s;
		x  = f * Q_STEP;
		x2 = (x * x) >> 16;
		t  = 64'd42334 - ((x2 * 64'd4926) >> 16);
		t  = 64'd102944 - ((x2 * t) >> 16);
		s  = ((x * t) >> 16) >> 1;
		if (s > 64'd32767) begin
			s = 64'd32767;
		end
		return s[14:0];
	endfunction

	function automatic qtr_tab_t build_qtr();
		qtr_tab_t tab;
		for (int i = 0; i < QTR; i++) begin
			tab[i] = sin_entry(longint'(i));
		end
		return tab;
	endfunction

	localparam qtr_tab_t SIN_QTR = build_qtr();

	// trapezoid table row, returned as {c, b, a}
	function automatic logic [5:0] trap_row(input logic wide, input logic [3:0] sec);
		logic [5:0] r;
		r = {COEF_NEG, COEF_POS, COEF_ZERO};
		if (!wide) begin
			case (sec)
				4'd0:    r = {COEF_NEG,  COEF_POS,  COEF_ZERO};
				4'd1:    r = {COEF_ZERO, COEF_POS,  COEF_NEG};
				4'd2:    r = {COEF_POS,  COEF_ZERO, COEF_NEG};
				4'd3:    r = {COEF_POS,  COEF_NEG,  COEF_ZERO};
				4'd4:    r = {COEF_ZERO, COEF_NEG,  COEF_POS};
				4'd5:    r = {COEF_NEG,  COEF_ZERO, COEF_POS};
				default: r = {COEF_NEG,  COEF_POS,  COEF_ZERO};
			endcase
		end else begin
			case (sec)
				4'd0:    r = {COEF_NEG,  COEF_POS,  COEF_ZERO};
				4'd1:    r = {COEF_NEG,  COEF_POS,  COEF_NEG};
				4'd2:    r = {COEF_ZERO, COEF_POS,  COEF_NEG};
				4'd3:    r = {COEF_POS,  COEF_POS,  COEF_NEG};
				4'd4:    r = {COEF_POS,  COEF_ZERO, COEF_NEG};
				4'd5:    r = {COEF_POS,  COEF_NEG,  COEF_NEG};
				4'd6:    r = {COEF_POS,  COEF_NEG,  COEF_ZERO};
				4'd7:    r = {COEF_POS,  COEF_NEG,  COEF_POS};
				4'd8:    r = {COEF_ZERO, COEF_NEG,  COEF_POS};
				4'd9:    r = {COEF_NEG,  COEF_NEG,  COEF_POS};
				4'd10:   r = {COEF_NEG,  COEF_ZERO, COEF_POS};
				4'd11:   r = {COEF_NEG,  COEF_POS,  COEF_POS};
				default: r = {COEF_NEG,  COEF_POS,  COEF_ZERO};
			endcase
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/fpvm_sine_rom.sv -----
// Dual-read sine/cosine lookup built on a one-quadrant constant table.
// Depends on fpvm_pkg (table, widths).
module fpvm_sine_rom (
	input  logic                                  clk,
	input  logic                                  en,
	input  logic [fpvm_pkg::ROM_AW-1:0]           idx,
	output logic signed [fpvm_pkg::VOLT_BITS-1:0] sin_val,
	output logic signed [fpvm_pkg::VOLT_BITS-1:0] cos_val
);

	// fold a full-turn index onto the quadrant table, then restore the sign
	function automatic logic signed [fpvm_pkg::VOLT_BITS-1:0] lookup(
		input logic [fpvm_pkg::ROM_AW-1:0] k
	);
		logic [1:0]                     quad;
		logic [fpvm_pkg::QTR_AW-1:0]    f;
		logic [fpvm_pkg::QTR_AW:0]      m;
		logic [14:0]                    mag;
		quad = k[fpvm_pkg::ROM_AW-1 -: 2];
		f    = k[fpvm_pkg::QTR_AW-1:0];
		m    = quad[0] ? ((fpvm_pkg::QTR_AW+1)'(fpvm_pkg::QTR) - {1'b0, f}) : {1'b0, f};
		if (m[fpvm_pkg::QTR_AW]) begin
			mag = fpvm_pkg::SIN_PEAK;
		end else begin
			mag = fpvm_pkg::SIN_QTR[m[fpvm_pkg::QTR_AW-1:0]];
		end
		return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	endfunction

	logic [fpvm_pkg::ROM_AW-1:0] idx_cos;
	assign idx_cos = idx + fpvm_pkg::ROM_AW'(fpvm_pkg::QTR);

	// registered read ports
	always_ff @(posedge clk) begin
		if (en) begin
			sin_val <= lookup(idx);
			cos_val <= lookup(idx_cos);
		end
	end

endmodule

// ----- hw/rtl/foc_phase_voltage_modulator.sv -----
// Phase voltage modulator top level: clamp, inverse Park/Clarke, SVPWM, trapezoid.
// Depends on fpvm_pkg, fpvm_sine_rom and foc_phase_voltage_modulator_defines.svh.
//
//  channel   | direction | payload
//  s_axis    | in        | tdata: uq[15:0], ud[31:16], angle[47:32]
//  m_axis    | out       | tdata: phase_a[17:0], phase_b[35:18], phase_c[53:36]
//  cfg       | in        | cfg_index (0 mode, 1 centered, 2 voltage_limit), cfg_data
//
// One request per cycle sustained while m_axis is not stalled; each request passes
// through the seven-stage datapath (lookup, products, Park, Clarke scale, Clarke sum,
// min/max, centring). Reset (arst_n low) empties the pipeline and loads mode SVPWM,
// centred, limit 16384. A stall on m_axis freezes every stage; nothing is lost.
// Configuration writes are always taken.
`include "foc_phase_voltage_modulator_defines.svh"

module foc_phase_voltage_modulator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // uq[15:0], ud[31:16], angle[47:32]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // phase_a[17:0], phase_b[35:18], phase_c[53:36], zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_data
);

	localparam int VB = fpvm_pkg::VOLT_BITS;
	localparam int OB = fpvm_pkg::OUT_BITS;
	localparam int PB = fpvm_pkg::PROD_BITS;
	localparam int AB = fpvm_pkg::ANGLE_BITS;

	// configuration registers
	fpvm_pkg::mode_t              mode_q;
	logic                         centered_q;
	logic [fpvm_pkg::LIM_BITS-1:0] limit_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= fpvm_pkg::MODE_SVPWM;
			centered_q <= 1'b1;
			limit_q    <= fpvm_pkg::LIM_BITS'(16384);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				fpvm_pkg::REG_MODE:     mode_q     <= fpvm_pkg::mode_t'(cfg_data[1:0]);
				fpvm_pkg::REG_CENTERED: centered_q <= cfg_data[0];
				fpvm_pkg::REG_LIMIT:    limit_q    <= cfg_data[fpvm_pkg::LIM_BITS-1:0];
				default: ;
			endcase
		end
	end

	// pipeline advance: the output register frees the whole chain
	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	assign en            = !vld_s7 || m_axis_tready;
	assign s_axis_tready = en;

	logic s_fire;
	assign s_fire = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7} <= '0;
		end else if (en) begin
			vld_s1 <= s_fire;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// stage 1: clamp commands, sector lookup, sine table read
	function automatic logic signed [VB-1:0] clamp_cmd(
		input logic signed [VB-1:0]             v,
		input logic [fpvm_pkg::LIM_BITS-1:0]    lim
	);
		logic signed [VB:0] vx, lx;
		vx = $signed({v[VB-1], v});
		lx = $signed({2'b00, lim});
		if (vx > lx) begin
			vx = lx;
		end else if (vx < -lx) begin
			vx = -lx;
		end
		return vx[VB-1:0];
	endfunction

	logic signed [VB-1:0] in_uq, in_ud;
	logic [AB-1:0]        in_angle;
	logic [AB-1:0]        ang_sh;
	logic [AB+3:0]        sec_prod;
	logic [3:0]           rows;
	logic                 wide;

	assign in_uq    = s_axis_tdata[15:0];
	assign in_ud    = s_axis_tdata[31:16];
	assign in_angle = s_axis_tdata[47:32];
	assign wide     = (mode_q == fpvm_pkg::MODE_TRAP150);
	assign rows     = wide ? 4'd12 : 4'd6;
	assign ang_sh   = in_angle + fpvm_pkg::TRAP_OFS;
	assign sec_prod = (AB+4)'(ang_sh) * (AB+4)'(rows);

	logic signed [VB-1:0] uq_s1, ud_s1;
	logic [5:0]           coef_s1;
	logic signed [VB-1:0] sin_s1, cos_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			uq_s1   <= clamp_cmd(in_uq, limit_q);
			ud_s1   <= clamp_cmd(in_ud, limit_q);
			coef_s1 <= fpvm_pkg::trap_row(wide, sec_prod[AB+3:AB]);
		end
	end

	fpvm_sine_rom u_rom (
		.clk     (clk),
		.en      (en),
		.idx     (in_angle[AB-1 -: fpvm_pkg::ROM_AW]),
		.sin_val (sin_s1),
		.cos_val (cos_s1)
	);

	// stage 2: the four Park products
	logic signed [PB-1:0] p_cd_s2, p_su_s2, p_sd_s2, p_cu_s2;
	logic signed [VB-1:0] uq_s2;
	logic [5:0]           coef_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			p_cd_s2 <= cos_s1 * ud_s1;
			p_su_s2 <= sin_s1 * uq_s1;
			p_sd_s2 <= sin_s1 * ud_s1;
			p_cu_s2 <= cos_s1 * uq_s1;
			uq_s2   <= uq_s1;
			coef_s2 <= coef_s1;
		end
	end

	// stage 3: alpha and beta, floor of Q15 scaling
	logic signed [PB:0]   al_sum, be_sum;
	logic signed [OB-1:0] al_s3, be_s3;
	logic signed [VB-1:0] uq_s3;
	logic [5:0]           coef_s3;

	assign al_sum = (PB+1)'(p_cd_s2) - (PB+1)'(p_su_s2);
	assign be_sum = (PB+1)'(p_sd_s2) + (PB+1)'(p_cu_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			al_s3   <= al_sum[PB:15];
			be_s3   <= be_sum[PB:15];
			uq_s3   <= uq_s2;
			coef_s3 <= coef_s2;
		end
	end

	// stage 4: beta times sqrt(3)/2
	logic signed [OB+VB-1:0] bm_s4;
	logic signed [OB-1:0]    al_s4;
	logic signed [VB-1:0]    uq_s4;
	logic [5:0]              coef_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			bm_s4   <= be_s3 * fpvm_pkg::SQRT3_2_Q15;
			al_s4   <= al_s3;
			uq_s4   <= uq_s3;
			coef_s4 <= coef_s3;
		end
	end

	// stage 5: inverse Clarke sums
	logic signed [OB+VB:0] al_sh, ub_sum, uc_sum;
	logic signed [OB-1:0]  ua_s5, ub_s5, uc_s5;
	logic signed [VB-1:0]  uq_s5;
	logic [5:0]            coef_s5;

	assign al_sh  = (OB+VB+1)'(al_s4) <<< 14;
	assign ub_sum = -al_sh + (OB+VB+1)'(bm_s4);
	assign uc_sum = -al_sh - (OB+VB+1)'(bm_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			ua_s5   <= al_s4;
			ub_s5   <= ub_sum[OB+14:15];
			uc_s5   <= uc_sum[OB+14:15];
			uq_s5   <= uq_s4;
			coef_s5 <= coef_s4;
		end
	end

	// stage 6: phase maximum and minimum
	logic signed [OB-1:0] mx_ab, mn_ab;
	logic signed [OB-1:0] ua_s6, ub_s6, uc_s6, max_s6, min_s6;
	logic signed [VB-1:0] uq_s6;
	logic [5:0]           coef_s6;

	assign mx_ab = (ua_s5 > ub_s5) ? ua_s5 : ub_s5;
	assign mn_ab = (ua_s5 < ub_s5) ? ua_s5 : ub_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			max_s6  <= (mx_ab > uc_s5) ? mx_ab : uc_s5;
			min_s6  <= (mn_ab < uc_s5) ? mn_ab : uc_s5;
			ua_s6   <= ua_s5;
			ub_s6   <= ub_s5;
			uc_s6   <= uc_s5;
			uq_s6   <= uq_s5;
			coef_s6 <= coef_s5;
		end
	end

	// stage 7: centre offset, add, saturate into the output register
	localparam int WB = OB + 2;

	function automatic logic signed [OB-1:0] sat_out(input logic signed [WB-1:0] v);
		logic signed [WB-1:0] hi, lo;
		hi = WB'((64'd1 << (OB - 1)) - 1);
		lo = -hi - WB'(1);
		if (v > hi) begin
			return hi[OB-1:0];
		end else if (v < lo) begin
			return lo[OB-1:0];
		end
		return v[OB-1:0];
	endfunction

	function automatic logic signed [WB-1:0] trap_term(
		input fpvm_pkg::coef_t      c,
		input logic signed [VB-1:0] u
	);
		logic signed [WB-1:0] r;
		case (c)
			fpvm_pkg::COEF_POS: r = WB'(u);
			fpvm_pkg::COEF_NEG: r = -WB'(u);
			default:            r = '0;
		endcase
		return r;
	endfunction

	logic signed [OB:0]   mm_sum;
	logic signed [WB-1:0] half, mid, center;
	logic signed [WB-1:0] term_a, term_b, term_c;
	logic                 trap;

	assign trap   = (mode_q == fpvm_pkg::MODE_TRAP120) || (mode_q == fpvm_pkg::MODE_TRAP150);
	assign mm_sum = (OB+1)'(max_s6) + (OB+1)'(min_s6);
	assign mid    = WB'($signed(mm_sum[OB:1]));
	assign half   = $signed({{(WB-fpvm_pkg::LIM_BITS+1){1'b0}}, limit_q[fpvm_pkg::LIM_BITS-1:1]});

	always_comb begin
		if (trap) begin
			center = centered_q ? half : WB'(uq_s6);
			term_a = trap_term(coef_s6[1:0], uq_s6);
			term_b = trap_term(coef_s6[3:2], uq_s6);
			term_c = trap_term(coef_s6[5:4], uq_s6);
		end else begin
			if (centered_q) begin
				center = (mode_q == fpvm_pkg::MODE_SVPWM) ? (half - mid) : half;
			end else begin
				center = -WB'(min_s6);
			end
			term_a = WB'(ua_s6);
			term_b = WB'(ub_s6);
			term_c = WB'(uc_s6);
		end
	end

	logic signed [OB-1:0] pa_s7, pb_s7, pc_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s7 <= sat_out(term_a + center);
			pb_s7 <= sat_out(term_b + center);
			pc_s7 <= sat_out(term_c + center);
		end
	end

	assign m_axis_tvalid = vld_s7;
	assign m_axis_tdata  = {2'b00, pc_s7, pb_s7, pa_s7};

	// checks on the pipeline control
	`FPVM_ASSERT_NEXT(a_accept_enters, clk, arst_n, s_fire, vld_s1, "accepted request did not enter stage 1")
	`FPVM_ASSERT_IMPLY(a_out_drops_only_taken, clk, arst_n, $fell(vld_s7), $past(m_axis_tready), "result dropped without being taken")
	`FPVM_ASSERT_NEXT(a_stall_holds_s1, clk, arst_n, vld_s1 && !en, vld_s1 && $stable(uq_s1) && $stable(coef_s1), "stage 1 changed during stall")
	`FPVM_ASSERT_NEXT(a_stall_holds_s6, clk, arst_n, vld_s6 && !en, vld_s6 && $stable(max_s6) && $stable(min_s6), "stage 6 changed during stall")

endmodule
